// ----- rtl/fke_pkg.sv -----
// Package with the shared constants, types and character codes of the k-mer extractor.
`default_nettype none
package fke_pkg;

    localparam int KMER_LENGTH = 32;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int COUNT_W     = 32;
    localparam int RUN_W       = $clog2(KMER_LENGTH + 1);
    localparam int CODE_W      = 2;

    localparam logic [RUN_W-1:0]   K_RUN   = RUN_W'(KMER_LENGTH);
    localparam logic [COUNT_W-1:0] K_COUNT = COUNT_W'(KMER_LENGTH);
    localparam logic [WORD_W-1:0]  KMER_MASK =
        (2 * KMER_LENGTH >= WORD_W) ? {WORD_W{1'b1}}
                                    : ((WORD_W'(1) << (2 * KMER_LENGTH)) - WORD_W'(1));

    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_G     = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;
    localparam logic [BYTE_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LO_Z  = 8'h7A;

    localparam logic [CODE_W-1:0] BASE_A = 2'd0;
    localparam logic [CODE_W-1:0] BASE_C = 2'd1;
    localparam logic [CODE_W-1:0] BASE_G = 2'd2;
    localparam logic [CODE_W-1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic              fire;
        logic [BYTE_W-1:0] text_byte;
    } step_req_t;

    typedef struct packed {
        logic               emit;
        logic [WORD_W-1:0]  kmer_word;
        logic [COUNT_W-1:0] sequence_number;
        logic [COUNT_W-1:0] start_position;
    } kmer_res_t;

endpackage
`default_nettype wire

// ----- rtl/fke_byte_if.sv -----
// Interfaces for the text byte channel and the k-mer result channel.
`default_nettype none
interface fke_byte_if;
    import fke_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface fke_kmer_if;
    import fke_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  kmer_word;
    logic [COUNT_W-1:0] sequence_number;
    logic [COUNT_W-1:0] start_position;

    modport source (output valid, output kmer_word, output sequence_number,
                    output start_position, input ready);
    modport sink   (input valid, input kmer_word, input sequence_number,
                    input start_position, output ready);
endinterface
`default_nettype wire

// ----- rtl/fke_in_reg.sv -----
// Input register holding one text byte request until the step logic takes it.
`default_nettype none
module fke_in_reg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    fke_byte_if.sink                          text,
    input  wire logic                         take,
    output fke_pkg::step_req_t                req
);
    import fke_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              accept;

    assign text.ready = !valid_reg || take;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= text.text_byte;
        end
    end

    assign req.fire      = valid_reg && take;
    assign req.text_byte = byte_reg;

endmodule
`default_nettype wire

// ----- rtl/fke_core.sv -----
// Parser state and combinational step logic: header skip, base packing and run counting.
`default_nettype none
module fke_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fke_pkg::step_req_t req,
    output fke_pkg::kmer_res_t      res
);
    import fke_pkg::*;

    logic [WORD_W-1:0]  packed_reg;
    logic [WORD_W-1:0]  packed_next;
    logic [RUN_W-1:0]   run_reg;
    logic [RUN_W-1:0]   run_next;
    logic [COUNT_W-1:0] index_reg;
    logic [COUNT_W-1:0] index_next;
    logic [COUNT_W-1:0] seq_reg;
    logic [COUNT_W-1:0] seq_next;
    logic               header_reg;
    logic               header_next;
    logic [CODE_W-1:0]  code;
    logic               good;
    logic               is_letter;
    logic               emit;
    logic [COUNT_W-1:0] index_inc;

    assign is_letter = ((req.text_byte >= CHAR_A) && (req.text_byte <= CHAR_UP_Z)) ||
                       ((req.text_byte >= CHAR_LO_A) && (req.text_byte <= CHAR_LO_Z));
    assign index_inc = (index_reg == {COUNT_W{1'b1}}) ? index_reg : index_reg + COUNT_W'(1);

    always_comb
    begin
        code = BASE_A;
        good = 1'b1;
        case (req.text_byte)
            CHAR_A:  code = BASE_A;
            CHAR_C:  code = BASE_C;
            CHAR_G:  code = BASE_G;
            CHAR_T:  code = BASE_T;
            default: good = 1'b0;
        endcase
    end

    always_comb
    begin
        packed_next = packed_reg;
        run_next    = run_reg;
        index_next  = index_reg;
        seq_next    = seq_reg;
        header_next = header_reg;
        emit        = 1'b0;
        if (req.fire)
        begin
            if (header_reg)
            begin
                if (req.text_byte == CHAR_NL)
                begin
                    header_next = 1'b0;
                end
            end
            else if (is_letter)
            begin
                packed_next = {packed_reg[WORD_W-CODE_W-1:0], code};
                if (!good)
                begin
                    run_next = '0;
                end
                else if (run_reg < K_RUN)
                begin
                    run_next = run_reg + RUN_W'(1);
                end
                index_next = index_inc;
                emit       = good && (run_next == K_RUN);
            end
            else if (req.text_byte == CHAR_GT)
            begin
                seq_next    = (seq_reg == {COUNT_W{1'b1}}) ? seq_reg : seq_reg + COUNT_W'(1);
                run_next    = '0;
                index_next  = index_inc;
                header_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packed_reg <= '0;
            run_reg    <= '0;
            index_reg  <= '0;
            seq_reg    <= '0;
            header_reg <= 1'b1;
        end
        else
        begin
            packed_reg <= packed_next;
            run_reg    <= run_next;
            index_reg  <= index_next;
            seq_reg    <= seq_next;
            header_reg <= header_next;
        end
    end

    assign res.emit            = emit;
    assign res.kmer_word       = packed_next & KMER_MASK;
    assign res.sequence_number = seq_reg;
    assign res.start_position  = index_next - K_COUNT;

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= K_RUN)
        else $error("run counter above k-mer length");

    a_emit_body: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (req.fire && !header_reg))
        else $error("result emitted outside sequence body");

    a_emit_run: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (run_reg == K_RUN))
        else $error("run not full after result");

    a_new_header: assert property (@(posedge clk) disable iff (!rst_n)
        (req.fire && !header_reg && (req.text_byte == CHAR_GT))
            |=> (header_reg && (run_reg == '0)))
        else $error("header start did not clear run");

endmodule
`default_nettype wire

// ----- rtl/fke_out_reg.sv -----
// Result register driving the k-mer channel.
`default_nettype none
module fke_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire fke_pkg::kmer_res_t res,
    output logic                    free,
    fke_kmer_if.source              kmer
);
    import fke_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [WORD_W-1:0]  word_reg;
    logic [COUNT_W-1:0] seq_reg;
    logic [COUNT_W-1:0] start_reg;

    assign free = !valid_reg || kmer.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res.emit;
        end
        else if (kmer.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.emit)
        begin
            word_reg  <= res.kmer_word;
            seq_reg   <= res.sequence_number;
            start_reg <= res.start_position;
        end
    end

    assign kmer.valid           = valid_reg;
    assign kmer.kmer_word       = word_reg;
    assign kmer.sequence_number = seq_reg;
    assign kmer.start_position  = start_reg;

endmodule
`default_nettype wire

// ----- rtl/fasta_kmer_extractor_top.sv -----
// Top level of the FASTA k-mer extractor: input register, step logic, result register.
// Each byte passes input register, step logic and result register in order.
// Throughput: one text byte per cycle while the result register is free. While
// a result waits on kmer.ready the step logic stalls, and the input register
// holds at most one byte. The step logic between the registers sets the rate.
// Reset (rst_n low, asynchronous) clears all counters and packed bases, empties
// both registers and puts the parser inside the first-line header.
`default_nettype none
module fasta_kmer_extractor_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fke_byte_if.sink   text,
    fke_kmer_if.source kmer
);
    import fke_pkg::*;

    step_req_t req;
    kmer_res_t res;
    logic      free;

    fke_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .take  (free),
        .req   (req)
    );

    fke_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    fke_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (req.fire),
        .res   (res),
        .free  (free),
        .kmer  (kmer)
    );

endmodule
`default_nettype wire
